### hw/rtl/dpt_pkg.sv
package dpt_pkg;

  // default configuration
  localparam int DEF_ADDRESS_BITS = 16;
  localparam int DEF_FRAME_COUNT  = 256;

  // fixed port widths
  localparam int ADDR_IN_W  = 16;
  localparam int FRAME_OUT_W = 8;
  localparam int OFFSET_OUT_W = 8;
  localparam int PHYS_OUT_W = 16;
  localparam int FAULT_W    = 32;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } dpt_state_t;

  // control from the sequencer to the datapath
  typedef struct packed {
    logic in_ready;
    logic rd_en;
    logic clr_wr;
    logic lookup;
  } dpt_ctrl_t;

endpackage

### hw/rtl/demand_paging_translator_core.sv
// the page table read is registered on the input beat, and the result is
//   registered from it in the lookup state once the output is free
// an address is taken only in the idle state, so a new address waits until
//   the previous one has been loaded into the result register
// reset: synchronous, active low; afterwards a clearing pass writes zero to
//   all 2**(ADDRESS_BITS/2) table entries (256 by default) with in_ready low
module demand_paging_translator_core #(
  parameter int ADDRESS_BITS = dpt_pkg::DEF_ADDRESS_BITS,
  parameter int FRAME_COUNT  = dpt_pkg::DEF_FRAME_COUNT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [dpt_pkg::ADDR_IN_W-1:0]      in_logical_address,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_page_missed,
  output logic [dpt_pkg::FRAME_OUT_W-1:0]    out_frame_number,
  output logic [dpt_pkg::OFFSET_OUT_W-1:0]   out_page_offset,
  output logic [dpt_pkg::PHYS_OUT_W-1:0]     out_physical_address,
  output logic                               out_memory_full,
  output logic [dpt_pkg::FAULT_W-1:0]        out_fault_total
);

  localparam int PAGE_BITS  = ADDRESS_BITS / 2;
  localparam int OFF_BITS   = ADDRESS_BITS - PAGE_BITS;
  localparam int PAGE_COUNT = 1 << PAGE_BITS;
  localparam int FRAME_BITS = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int CNT_BITS   = $clog2(FRAME_COUNT + 1);
  localparam int WORD_W     = FRAME_BITS + 1;
  localparam int PHYS_W     = FRAME_BITS + OFF_BITS;

  dpt_pkg::dpt_state_t state_r, state_nxt;
  dpt_pkg::dpt_ctrl_t  ctrl;

  logic [PAGE_BITS-1:0]  clr_idx_r, clr_idx_nxt;
  logic [PAGE_BITS-1:0]  page_r, page_nxt;
  logic [OFF_BITS-1:0]   off_r, off_nxt;
  logic [CNT_BITS-1:0]   alloc_cnt_r, alloc_cnt_nxt;
  logic [dpt_pkg::FAULT_W-1:0] fault_cnt_r, fault_cnt_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  missed_r, missed_nxt;
  logic                  full_r, full_nxt;
  logic [dpt_pkg::FRAME_OUT_W-1:0]  frame_r, frame_nxt;
  logic [dpt_pkg::OFFSET_OUT_W-1:0] offset_r, offset_nxt;
  logic [dpt_pkg::PHYS_OUT_W-1:0]   phys_r, phys_nxt;

  logic [ADDRESS_BITS-1:0] addr;
  logic [ADDRESS_BITS+dpt_pkg::ADDR_IN_W-1:0] addr_ext;
  logic [PAGE_BITS-1:0]  in_page;

  logic                  ram_we;
  logic [PAGE_BITS-1:0]  ram_waddr;
  logic [WORD_W-1:0]     ram_wdata;
  logic [WORD_W-1:0]     ram_rdata;

  logic                  hit;
  logic                  no_free;
  logic                  load;
  logic [FRAME_BITS-1:0] new_frame;
  logic [FRAME_BITS-1:0] res_frame;
  logic [PHYS_W-1:0]     phys_full;
  logic [PHYS_W+dpt_pkg::PHYS_OUT_W-1:0]   phys_ext;
  logic [FRAME_BITS+dpt_pkg::FRAME_OUT_W-1:0] frame_ext;
  logic [OFF_BITS+dpt_pkg::OFFSET_OUT_W-1:0]  off_ext;

  // input bits above ADDRESS_BITS are dropped, missing ones read as zero
  assign addr_ext = {{ADDRESS_BITS{1'b0}}, in_logical_address};
  assign addr     = addr_ext[ADDRESS_BITS-1:0];
  assign in_page  = addr[ADDRESS_BITS-1:OFF_BITS];

  dpt_ram #(
    .WIDTH (WORD_W),
    .DEPTH (PAGE_COUNT)
  ) u_table (
    .clk       (clk),
    .wr_en     (ram_we),
    .wr_addr   (ram_waddr),
    .wr_data   (ram_wdata),
    .rd_en     (ctrl.rd_en),
    .rd_addr   (in_page),
    .rd_data_r (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dpt_pkg::ST_CLEAR: begin
        if (&clr_idx_r) state_nxt = dpt_pkg::ST_IDLE;
      end
      dpt_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = dpt_pkg::ST_LOOKUP;
      end
      dpt_pkg::ST_LOOKUP: begin
        if (!out_valid_r || out_ready) state_nxt = dpt_pkg::ST_IDLE;
      end
      default: state_nxt = dpt_pkg::ST_CLEAR;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctrl = '0;
    case (state_r)
      dpt_pkg::ST_CLEAR: begin
        ctrl.clr_wr = 1'b1;
      end
      dpt_pkg::ST_IDLE: begin
        ctrl.in_ready = 1'b1;
        ctrl.rd_en    = in_valid;
      end
      dpt_pkg::ST_LOOKUP: begin
        ctrl.lookup = 1'b1;
      end
      default: ctrl = '0;
    endcase
  end

  assign in_ready = ctrl.in_ready;

  // lookup and allocation; frames are never freed, so the lowest free
  // frame is always the number already handed out
  assign hit       = ram_rdata[WORD_W-1];
  assign no_free   = (alloc_cnt_r == CNT_BITS'(FRAME_COUNT));
  assign new_frame = alloc_cnt_r[FRAME_BITS-1:0];
  assign load      = ctrl.lookup && (!out_valid_r || out_ready);
  assign res_frame = hit ? ram_rdata[FRAME_BITS-1:0] :
                     (no_free ? '0 : new_frame);

  assign ram_we    = ctrl.clr_wr || (load && !hit && !no_free);
  assign ram_waddr = ctrl.clr_wr ? clr_idx_r : page_r;
  assign ram_wdata = ctrl.clr_wr ? '0 : {1'b1, new_frame};

  assign phys_full = {res_frame, off_r};
  assign phys_ext  = {{dpt_pkg::PHYS_OUT_W{1'b0}}, phys_full};
  assign frame_ext = {{dpt_pkg::FRAME_OUT_W{1'b0}}, res_frame};
  assign off_ext   = {{dpt_pkg::OFFSET_OUT_W{1'b0}}, off_r};

  always_comb begin
    clr_idx_nxt   = clr_idx_r;
    page_nxt      = page_r;
    off_nxt       = off_r;
    alloc_cnt_nxt = alloc_cnt_r;
    fault_cnt_nxt = fault_cnt_r;
    out_valid_nxt = out_valid_r;
    missed_nxt    = missed_r;
    full_nxt      = full_r;
    frame_nxt     = frame_r;
    offset_nxt    = offset_r;
    phys_nxt      = phys_r;

    if (ctrl.clr_wr) clr_idx_nxt = clr_idx_r + 1'b1;

    if (ctrl.rd_en) begin
      page_nxt = in_page;
      off_nxt  = addr[OFF_BITS-1:0];
    end

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    if (load) begin
      out_valid_nxt = 1'b1;
      missed_nxt    = !hit;
      full_nxt      = !hit && no_free;
      frame_nxt     = frame_ext[dpt_pkg::FRAME_OUT_W-1:0];
      offset_nxt    = off_ext[dpt_pkg::OFFSET_OUT_W-1:0];
      phys_nxt      = (!hit && no_free) ? '0 : phys_ext[dpt_pkg::PHYS_OUT_W-1:0];
      if (!hit) begin
        // saturating fault count
        if (fault_cnt_r != '1) fault_cnt_nxt = fault_cnt_r + 1'b1;
        if (!no_free) alloc_cnt_nxt = alloc_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dpt_pkg::ST_CLEAR;
      clr_idx_r   <= '0;
      alloc_cnt_r <= '0;
      fault_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      alloc_cnt_r <= alloc_cnt_nxt;
      fault_cnt_r <= fault_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r   <= page_nxt;
    off_r    <= off_nxt;
    missed_r <= missed_nxt;
    full_r   <= full_nxt;
    frame_r  <= frame_nxt;
    offset_r <= offset_nxt;
    phys_r   <= phys_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_page_missed      = missed_r;
  assign out_memory_full      = full_r;
  assign out_frame_number     = frame_r;
  assign out_page_offset      = offset_r;
  assign out_physical_address = phys_r;
  assign out_fault_total      = fault_cnt_r;

endmodule

### hw/rtl/dpt_ram.sv
module dpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/dpt_checker.sv
module dpt_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             out_page_missed,
  input logic [dpt_pkg::FRAME_OUT_W-1:0]  out_frame_number,
  input logic [dpt_pkg::OFFSET_OUT_W-1:0] out_page_offset,
  input logic [dpt_pkg::PHYS_OUT_W-1:0]   out_physical_address,
  input logic                             out_memory_full,
  input logic [dpt_pkg::FAULT_W-1:0]      out_fault_total
);

  // nothing taken or shown while the table is being cleared
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("ready or valid high straight after reset");

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_number)
      && $stable(out_physical_address) && $stable(out_fault_total)
      && $stable(out_page_missed) && $stable(out_page_offset))
    else $error("result beat changed while stalled");

  // full only on a fault, and then no frame is given
  a_full_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_memory_full |->
      out_page_missed && out_frame_number == '0 && out_physical_address == '0)
    else $error("memory full beat with inconsistent fields");

  // a fault beat always carries a non-zero fault total
  a_fault_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_page_missed |-> out_fault_total != '0)
    else $error("fault reported with zero fault total");

  // one item in flight: no input beat while the previous lookup is pending
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

endmodule

bind demand_paging_translator_core dpt_checker u_dpt_checker (.*);
